[src/kac_pkg.sv]
// Shared constants, types and helpers for the keypad alarm clock.
// No dependencies; imported by the top level and its checker.
package kac_pkg;

    // Configuration register map
    localparam int          CFG_ADDR_W       = 3;
    localparam logic [15:0] TICK_LIMIT_RESET = 16'd5574;

    // Time wrap points
    localparam logic [6:0] SECONDS_WRAP = 7'd60;
    localparam logic [6:0] MINUTES_WRAP = 7'd100;

    // Key codes (ASCII)
    localparam logic [7:0] KEY_ZERO   = 8'd48;
    localparam logic [7:0] KEY_COMMIT = 8'h41;  // 'A'
    localparam logic [7:0] KEY_CANCEL = 8'h42;  // 'B'
    localparam logic [7:0] KEY_ARM    = 8'h43;  // 'C'
    localparam logic [7:0] KEY_SET_T  = 8'h44;  // 'D'
    localparam logic [7:0] KEY_SET_A  = 8'h45;  // 'E'

    // Item command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    // Mode codes as shown on the mode port
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_SET_TIME = 3'd1;
    localparam logic [2:0] MODE_SET_ALRM = 3'd2;
    localparam logic [2:0] MODE_ALRM_OFF = 3'd3;
    localparam logic [2:0] MODE_WAITING  = 3'd4;
    localparam logic [2:0] MODE_RINGING  = 3'd5;

    // One result item
    typedef struct packed {
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [13:0] entry;
        logic        show_entry;
        logic        blink_all;
        logic        armed;
        logic [2:0]  mode;
    } result_t;

    // Two BCD digits to binary (0..99)
    function automatic logic [6:0] bcd2_to_bin(input logic [7:0] bcd);
        logic [6:0] tens;
        tens = {3'b000, bcd[7:4]};
        return 7'((tens << 3) + (tens << 1) + {3'b000, bcd[3:0]});
    endfunction

    // Four BCD digits to binary (0..9999)
    function automatic logic [13:0] bcd4_to_bin(input logic [15:0] bcd);
        logic [13:0] hi;
        logic [13:0] lo;
        hi = {7'b0, bcd2_to_bin(bcd[15:8])};
        lo = {7'b0, bcd2_to_bin(bcd[7:0])};
        return 14'((hi << 6) + (hi << 5) + (hi << 2) + lo);
    endfunction

endpackage

[src/keypad_alarm_clock.sv]
// Keypad alarm clock: min:sec clock with prescaler, keypad entry and alarm.
// Depends on kac_pkg for key codes, mode codes and BCD helpers.
// A result enters the result register when its item is accepted, or the skid stage while result_stall holds it.
// Throughput: one item per cycle while item_stall is low; a single update pass sits between the
// state registers and the result register, backed by a one-entry skid stage.
// item_stall rises only while both the result register and the skid stage hold results.
// Reset (rst_n low, asynchronous): all clock state zero, tick limit 5574, no results.
module keypad_alarm_clock
    import kac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB-style configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // Item channel
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  command,
    input  logic [7:0]            key_code,
    // Result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [6:0]            shown_minutes,
    output logic [6:0]            shown_seconds,
    output logic [13:0]           entry_value,
    output logic                  show_entry,
    output logic                  blink_all,
    output logic                  alarm_armed,
    output logic [2:0]            mode
);

    typedef enum logic [2:0] {
        ST_IDLE     = MODE_IDLE,
        ST_SET_TIME = MODE_SET_TIME,
        ST_SET_ALRM = MODE_SET_ALRM,
        ST_ALRM_OFF = MODE_ALRM_OFF,
        ST_WAITING  = MODE_WAITING,
        ST_RINGING  = MODE_RINGING
    } state_t;

    state_t      state_reg, state_next;
    state_t      mode_evt;
    logic [15:0] tick_limit_reg, tick_limit_next;
    logic [15:0] prescale_reg, prescale_next;
    logic [6:0]  seconds_reg, seconds_next;
    logic [6:0]  minutes_reg, minutes_next;
    logic [15:0] entry_bcd_reg, entry_bcd_next;
    logic [13:0] alarm_reg, alarm_next;
    logic        armed_reg, armed_next;

    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    result_t     skid_reg, skid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        cfg_write;
    logic        accept;
    logic        take;
    logic        is_tick;
    logic        is_digit;
    logic [7:0]  digit_code;
    logic [16:0] prescale_inc;
    logic        second_done;
    logic [6:0]  seconds_inc;
    logic [6:0]  minutes_inc;
    logic [13:0] entry_bin;
    logic [13:0] now_next;
    result_t     result_new;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == 1'b0) ? {16'b0, tick_limit_reg} : 32'b0;

    always_comb
    begin
        tick_limit_next = tick_limit_reg;
        if (cfg_write && paddr[2] == 1'b0)
        begin
            tick_limit_next = pwdata[15:0];
        end
    end

    // Handshakes
    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign take         = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;

    // Event decode
    assign is_tick    = (command == CMD_TICK);
    assign digit_code = key_code - KEY_ZERO;
    assign is_digit   = (key_code >= KEY_ZERO) && (digit_code < 8'd10);

    // Prescaler and second carry
    assign prescale_inc = {1'b0, prescale_reg} + 17'd1;
    assign second_done  = is_tick && (prescale_inc >= {1'b0, tick_limit_reg});
    assign seconds_inc  = seconds_reg + 7'd1;
    assign minutes_inc  = minutes_reg + 7'd1;

    // Update pass for one item
    always_comb
    begin
        prescale_next  = prescale_reg;
        seconds_next   = seconds_reg;
        minutes_next   = minutes_reg;
        entry_bcd_next = entry_bcd_reg;
        alarm_next     = alarm_reg;
        armed_next     = armed_reg;
        mode_evt       = state_reg;
        if (accept)
        begin
            if (is_tick)
            begin
                prescale_next = second_done ? 16'd0 : prescale_inc[15:0];
                if (second_done)
                begin
                    if (seconds_inc >= SECONDS_WRAP)
                    begin
                        seconds_next = 7'd0;
                        minutes_next = (minutes_inc >= MINUTES_WRAP) ? 7'd0 : minutes_inc;
                    end
                    else
                    begin
                        seconds_next = seconds_inc;
                    end
                end
            end
            else
            begin
                // other key codes leave the state alone
                if (is_digit)
                begin
                    // shift in a digit, oldest digit drops out
                    entry_bcd_next = {entry_bcd_reg[11:0], digit_code[3:0]};
                end
                else if (key_code == KEY_COMMIT)
                begin
                    if (state_reg == ST_SET_TIME)
                    begin
                        minutes_next = bcd2_to_bin(entry_bcd_reg[15:8]);
                        seconds_next = bcd2_to_bin(entry_bcd_reg[7:0]);
                    end
                    else if (state_reg == ST_SET_ALRM)
                    begin
                        alarm_next = bcd4_to_bin(entry_bcd_reg);
                    end
                    entry_bcd_next = 16'd0;
                    mode_evt       = ST_IDLE;
                end
                else if (key_code == KEY_CANCEL)
                begin
                    entry_bcd_next = 16'd0;
                    mode_evt       = ST_IDLE;
                end
                else if (key_code == KEY_ARM)
                begin
                    armed_next = !armed_reg;
                    mode_evt   = ST_WAITING;
                end
                else if (key_code == KEY_SET_T)
                begin
                    mode_evt = ST_SET_TIME;
                end
                else if (key_code == KEY_SET_A)
                begin
                    mode_evt = ST_SET_ALRM;
                end
            end
        end
    end

    assign now_next  = 14'(({7'b0, minutes_next} << 6) + ({7'b0, minutes_next} << 5)
                         + ({7'b0, minutes_next} << 2)) + {7'b0, seconds_next};
    assign entry_bin = bcd4_to_bin(entry_bcd_next);

    // Alarm match on the updated time
    always_comb
    begin
        state_next = mode_evt;
        if (accept && armed_next && now_next != 14'd0 && now_next == alarm_next)
        begin
            state_next = ST_RINGING;
        end
    end

    // Result item
    always_comb
    begin
        result_new.minutes    = minutes_next;
        result_new.seconds    = seconds_next;
        result_new.entry      = entry_bin;
        result_new.show_entry = (state_next == ST_SET_TIME) || (state_next == ST_SET_ALRM);
        result_new.blink_all  = (state_next == ST_SET_ALRM) || (state_next == ST_RINGING);
        result_new.armed      = armed_next;
        result_new.mode       = state_next;
    end

    // Result register and skid stage
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = result_new;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result_new;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_limit_reg <= TICK_LIMIT_RESET;
            prescale_reg   <= 16'd0;
            seconds_reg    <= 7'd0;
            minutes_reg    <= 7'd0;
            entry_bcd_reg  <= 16'd0;
            alarm_reg      <= 14'd0;
            armed_reg      <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_reg       <= '0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_limit_reg <= tick_limit_next;
            prescale_reg   <= prescale_next;
            seconds_reg    <= seconds_next;
            minutes_reg    <= minutes_next;
            entry_bcd_reg  <= entry_bcd_next;
            alarm_reg      <= alarm_next;
            armed_reg      <= armed_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            skid_reg       <= skid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign shown_minutes = out_reg.minutes;
    assign shown_seconds = out_reg.seconds;
    assign entry_value   = out_reg.entry;
    assign show_entry    = out_reg.show_entry;
    assign blink_all     = out_reg.blink_all;
    assign alarm_armed   = out_reg.armed;
    assign mode          = out_reg.mode;

endmodule

[src/kac_checker.sv]
// Port-level checker for the keypad alarm clock, bound to the top level.
// Depends on kac_pkg for mode codes.
module kac_checker
    import kac_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic       show_entry,
    input logic       blink_all,
    input logic [2:0] mode
);

    // Stall only while a result is held back
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item_stall without a pending result");

    // Every accepted item leaves a result visible next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> result_valid)
        else $error("accepted item produced no result");

    // A stalled result stays presented
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(mode)))
        else $error("stalled result dropped or changed");

    // Display flags agree with the mode
    a_show_entry: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (show_entry == (mode == MODE_SET_TIME || mode == MODE_SET_ALRM)))
        else $error("show_entry does not match mode");

    a_blink_all: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (blink_all == (mode == MODE_SET_ALRM || mode == MODE_RINGING)))
        else $error("blink_all does not match mode");

endmodule

bind keypad_alarm_clock kac_checker u_kac_checker (.*);
